// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the port-level checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is active
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== sv/jsu_pkg.sv =====
// ---------------------------------------------------------------------------
// jsu_pkg
// Shared types, codes and helper functions of the JSON string unescaper.
// ---------------------------------------------------------------------------
package jsu_pkg;

  // Result status codes
  localparam logic [1:0] ST_BYTE  = 2'd0;
  localparam logic [1:0] ST_CLOSE = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  // Number of result words one input word can cause at most
  localparam int unsigned MAX_RES = 7;

  // Characters with a meaning to the decoder
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_U     = 8'h75;

  // Code points and surrogate tags
  localparam logic [20:0] CP_REPL      = 21'h00FFFD;
  localparam logic [20:0] CP_SUPP_BASE = 21'h010000;
  localparam logic [5:0]  SUR_HIGH_TAG = 6'b110110;
  localparam logic [5:0]  SUR_LOW_TAG  = 6'b110111;

  // Decoder phase, one-hot
  typedef enum logic [6:0] {
    PH_IDLE     = 7'b0000001,
    PH_BODY     = 7'b0000010,
    PH_ESC      = 7'b0000100,
    PH_HEX      = 7'b0001000,
    PH_HELD     = 7'b0010000,
    PH_HELD_ESC = 7'b0100000,
    PH_LOW_HEX  = 7'b1000000
  } phase_t;

  // UTF-8 encoding of one code point
  typedef struct packed {
    logic [3:0][7:0] bytes;  // bytes[0] goes out first
    logic [2:0]      len;
  } utf8_t;

  // Hex digit decode
  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic utf8_t utf8_enc(input logic [20:0] cp);
    utf8_t u;
    u.bytes = '0;
    if (cp <= 21'h7F) begin
      u.len      = 3'd1;
      u.bytes[0] = {1'b0, cp[6:0]};
    end else if (cp <= 21'h7FF) begin
      u.len      = 3'd2;
      u.bytes[0] = {3'b110, cp[10:6]};
      u.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      u.len      = 3'd3;
      u.bytes[0] = {4'b1110, cp[15:12]};
      u.bytes[1] = {2'b10, cp[11:6]};
      u.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      u.len      = 3'd4;
      u.bytes[0] = {5'b11110, cp[20:18]};
      u.bytes[1] = {2'b10, cp[17:12]};
      u.bytes[2] = {2'b10, cp[11:6]};
      u.bytes[3] = {2'b10, cp[5:0]};
    end
    return u;
  endfunction

endpackage

// ===== sv/json_string_unescape_utf8_top.sv =====
// Flow: result words of an accepted input word go through the result buffer, then
//   the output register. Throughput: one input word per cycle while each causes at
//   most one result word and the output is not stalled; a word with more results
//   holds the input until the single-word output port drains the result buffer.
// Reset: synchronous active-low rst_n returns the decoder to idle and empties
//   the result buffer and output register; no clearing pass.
// ---------------------------------------------------------------------------
// json_string_unescape_utf8_top
// Unescapes a quoted JSON string one byte per word and emits UTF-8 bytes,
// followed by a close or error status word.
// ---------------------------------------------------------------------------
module json_string_unescape_utf8_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_first,
  input  logic       in_final_req,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] out_status,
  output logic       out_run_end
);
  import jsu_pkg::*;

  // Decoder state
  phase_t      phase_r, phase_nxt;
  logic [15:0] hex_r, hex_nxt;
  logic [1:0]  dc_r, dc_nxt;
  logic [9:0]  held_r, held_nxt;

  // Result buffer for one input word
  logic [7:0] buf_byte_r [MAX_RES];
  logic [1:0] buf_stat_r [MAX_RES];
  logic [2:0] buf_cnt_r;
  logic [7:0] lst_byte_nxt [MAX_RES];
  logic [1:0] lst_stat_nxt [MAX_RES];
  logic [2:0] lst_cnt_nxt;

  // Output register
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic [1:0] out_stat_r;
  logic       out_end_r;

  logic load_out, in_acc;

  // Advance the output register when empty or taken
  assign load_out = !out_valid_r || out_ready;
  assign in_ready = (buf_cnt_r == 3'd0) || (buf_cnt_r == 3'd1 && load_out);
  assign in_acc   = in_valid && in_ready;

  assign out_valid   = out_valid_r;
  assign out_byte    = out_byte_r;
  assign out_status  = out_stat_r;
  assign out_run_end = out_end_r;

  // Decode one input word into its list of result words
  hex_t        hd;
  logic [15:0] gathered;
  logic        pre_fffd, do_body, do_esc, do_lone, do_pair, do_err;
  logic        raw_en, enc_en, term_en, fin_err;
  logic [7:0]  raw_byte;
  logic [20:0] enc_cp;
  logic [1:0]  term_stat;
  utf8_t       enc;
  logic [2:0]  n;

  always_comb begin
    hd        = hex_digit(in_byte);
    gathered  = {hex_r[11:0], hd.val};
    phase_nxt = phase_r;
    hex_nxt   = hex_r;
    dc_nxt    = dc_r;
    held_nxt  = held_r;
    pre_fffd  = 1'b0;
    do_body   = 1'b0;
    do_esc    = 1'b0;
    do_lone   = 1'b0;
    do_pair   = 1'b0;
    do_err    = 1'b0;
    raw_en    = 1'b0;
    raw_byte  = in_byte;
    enc_en    = 1'b0;
    enc_cp    = CP_REPL;
    term_en   = 1'b0;
    term_stat = ST_CLOSE;

    // Pick the action for this byte
    if (in_first) begin
      phase_nxt = PH_BODY;
      hex_nxt   = '0;
      dc_nxt    = '0;
      held_nxt  = '0;
      if (in_byte != CH_QUOTE) do_err = 1'b1;
    end else begin
      case (phase_r)
        PH_BODY: do_body = 1'b1;
        PH_ESC:  do_esc  = 1'b1;
        PH_HEX: begin
          if (!hd.ok) begin
            do_err = 1'b1;
          end else begin
            hex_nxt = gathered;
            if (dc_r == 2'd3) begin
              dc_nxt  = 2'd0;
              do_lone = 1'b1;
            end else begin
              dc_nxt = dc_r + 2'd1;
            end
          end
        end
        PH_HELD: begin
          if (in_byte == CH_BSL) begin
            phase_nxt = PH_HELD_ESC;
          end else begin
            pre_fffd = 1'b1;
            do_body  = 1'b1;
          end
        end
        PH_HELD_ESC: begin
          if (in_byte == CH_U) begin
            hex_nxt   = '0;
            dc_nxt    = '0;
            phase_nxt = PH_LOW_HEX;
          end else begin
            pre_fffd = 1'b1;
            do_esc   = 1'b1;
          end
        end
        PH_LOW_HEX: begin
          if (!hd.ok) begin
            do_err = 1'b1;
          end else begin
            hex_nxt = gathered;
            if (dc_r == 2'd3) begin
              dc_nxt = 2'd0;
              if (gathered[15:10] == SUR_LOW_TAG) begin
                do_pair = 1'b1;
              end else begin
                pre_fffd = 1'b1;
                do_lone  = 1'b1;
              end
            end else begin
              dc_nxt = dc_r + 2'd1;
            end
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end

    // Plain string body byte
    if (do_body) begin
      phase_nxt = PH_BODY;
      if (in_byte == CH_QUOTE) begin
        term_en = 1'b1;
      end else if (in_byte == CH_BSL) begin
        phase_nxt = PH_ESC;
      end else begin
        raw_en = 1'b1;
      end
    end

    // Byte after a backslash
    if (do_esc) begin
      phase_nxt = PH_BODY;
      raw_en    = 1'b1;
      case (in_byte)
        CH_QUOTE: raw_byte = CH_QUOTE;
        CH_BSL:   raw_byte = CH_BSL;
        CH_SLASH: raw_byte = CH_SLASH;
        CH_N:     raw_byte = 8'h0A;
        CH_R:     raw_byte = 8'h0D;
        CH_T:     raw_byte = 8'h09;
        CH_B:     raw_byte = 8'h08;
        CH_F:     raw_byte = 8'h0C;
        CH_U: begin
          raw_en    = 1'b0;
          hex_nxt   = '0;
          dc_nxt    = '0;
          phase_nxt = PH_HEX;
        end
        default: begin
          raw_en = 1'b0;
          do_err = 1'b1;
        end
      endcase
    end

    // Code unit standing on its own
    if (do_lone) begin
      if (gathered[15:10] == SUR_HIGH_TAG) begin
        held_nxt  = gathered[9:0];
        phase_nxt = PH_HELD;
      end else begin
        phase_nxt = PH_BODY;
        enc_en    = 1'b1;
        enc_cp    = (gathered[15:10] == SUR_LOW_TAG) ? CP_REPL : {5'd0, gathered};
      end
    end

    // High and low surrogate joined into one code point
    if (do_pair) begin
      phase_nxt = PH_BODY;
      enc_en    = 1'b1;
      enc_cp    = CP_SUPP_BASE + {1'b0, held_r, gathered[9:0]};
    end

    if (do_err) begin
      term_en   = 1'b1;
      term_stat = ST_ERROR;
    end

    // Close or error drops all state
    if (term_en) begin
      phase_nxt = PH_IDLE;
      hex_nxt   = '0;
      dc_nxt    = '0;
      held_nxt  = '0;
    end

    // Text ended without a close
    fin_err = in_final_req && (phase_nxt != PH_IDLE);
    if (fin_err) begin
      phase_nxt = PH_IDLE;
      hex_nxt   = '0;
      dc_nxt    = '0;
      held_nxt  = '0;
    end

    // Build the result list in order
    enc = utf8_enc(enc_cp);
    n   = 3'd0;
    for (int i = 0; i < MAX_RES; i++) begin
      lst_byte_nxt[i] = 8'd0;
      lst_stat_nxt[i] = ST_BYTE;
    end
    if (pre_fffd) begin
      lst_byte_nxt[0] = 8'hEF;
      lst_byte_nxt[1] = 8'hBF;
      lst_byte_nxt[2] = 8'hBD;
      n = 3'd3;
    end
    if (raw_en) begin
      lst_byte_nxt[n] = raw_byte;
      n = n + 3'd1;
    end
    if (enc_en) begin
      for (int i = 0; i < 4; i++) begin
        if (3'(i) < enc.len) begin
          lst_byte_nxt[n] = enc.bytes[i];
          n = n + 3'd1;
        end
      end
    end
    if (term_en) begin
      lst_stat_nxt[n] = term_stat;
      n = n + 3'd1;
    end
    if (fin_err) begin
      lst_stat_nxt[n] = ST_ERROR;
      n = n + 3'd1;
    end
    lst_cnt_nxt = n;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      hex_r       <= '0;
      dc_r        <= '0;
      held_r      <= '0;
      buf_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out) out_valid_r <= (buf_cnt_r != 3'd0);
      if (in_acc) begin
        phase_r   <= phase_nxt;
        hex_r     <= hex_nxt;
        dc_r      <= dc_nxt;
        held_r    <= held_nxt;
        buf_cnt_r <= lst_cnt_nxt;
      end else if (load_out && buf_cnt_r != 3'd0) begin
        buf_cnt_r <= buf_cnt_r - 3'd1;
      end
    end
  end

  // Payload: load a new list, or shift the buffer as words leave
  always_ff @(posedge clk) begin
    if (load_out && buf_cnt_r != 3'd0) begin
      out_byte_r <= buf_byte_r[0];
      out_stat_r <= buf_stat_r[0];
      out_end_r  <= (buf_cnt_r == 3'd1);
    end
    if (in_acc) begin
      buf_byte_r <= lst_byte_nxt;
      buf_stat_r <= lst_stat_nxt;
    end else if (load_out && buf_cnt_r != 3'd0) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        buf_byte_r[i] <= buf_byte_r[i+1];
        buf_stat_r[i] <= buf_stat_r[i+1];
      end
    end
  end

endmodule

// ===== sv/jsu_checker.sv =====
// ---------------------------------------------------------------------------
// jsu_checker
// Port-level checks on the result channel of the JSON string unescaper.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module jsu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic [1:0] out_status,
  input logic       out_run_end
);
  import jsu_pkg::*;

  // Hold a stalled result word
  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_byte))
  // Status is one of the three codes
  `CHK_IMPLY(a_stat_code, clk, rst_n, out_valid, out_status != 2'd3)
  // Close and error words carry no byte
  `CHK_IMPLY(a_stat_zero, clk, rst_n, out_valid && out_status != ST_BYTE, out_byte == 8'd0)
  // Close and error always end the run of an input word
  `CHK_IMPLY(a_stat_end, clk, rst_n, out_valid && out_status != ST_BYTE, out_run_end)

endmodule

bind json_string_unescape_utf8_top jsu_checker u_jsu_checker (.*);

// ===== sim/json_string_unescape_utf8_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_checker
// Watches both channels of the JSON string unescaper. For each accepted text
// byte it works out the decoded result words in its own decoder copy and
// compares every word that comes out with the oldest one still due.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_first,
  input  logic       in_final_req,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic [1:0] out_status,
  input  logic       out_run_end,
  output int         n_fail,
  output int         n_pending
);
  import jsu_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] status;
    logic       run_end;
  } dec_word_t;

  // Decoder copy
  phase_t      dec_phase;
  logic [15:0] dec_acc;
  logic [1:0]  dec_ndig;
  logic [9:0]  dec_held;

  dec_word_t   step_words[$];
  dec_word_t   due_words[$];

  function automatic void add_word(input logic [7:0] data, input logic [1:0] status);
    dec_word_t w;
    if (step_words.size() >= MAX_RES) return;
    w.data    = (status == ST_BYTE) ? data : 8'h00;
    w.status  = status;
    w.run_end = 1'b0;
    step_words.insert(step_words.size(), w);
  endfunction

  function automatic void clear_decoder();
    dec_phase = PH_IDLE;
    dec_acc   = '0;
    dec_ndig  = '0;
    dec_held  = '0;
  endfunction

  function automatic void close_text(input logic [1:0] status);
    add_word(8'h00, status);
    clear_decoder();
  endfunction

  // Encode one code point as UTF-8 bytes
  function automatic void add_code_point(input logic [20:0] cp);
    if (cp < 21'h80) begin
      add_word(8'(cp), ST_BYTE);
    end else if (cp < 21'h800) begin
      add_word(8'hC0 | 8'(cp >> 6), ST_BYTE);
      add_word(8'h80 | 8'(cp & 21'h3F), ST_BYTE);
    end else if (cp < 21'h10000) begin
      add_word(8'hE0 | 8'(cp >> 12), ST_BYTE);
      add_word(8'h80 | 8'((cp >> 6) & 21'h3F), ST_BYTE);
      add_word(8'h80 | 8'(cp & 21'h3F), ST_BYTE);
    end else begin
      add_word(8'hF0 | 8'(cp >> 18), ST_BYTE);
      add_word(8'h80 | 8'((cp >> 12) & 21'h3F), ST_BYTE);
      add_word(8'h80 | 8'((cp >> 6) & 21'h3F), ST_BYTE);
      add_word(8'h80 | 8'(cp & 21'h3F), ST_BYTE);
    end
  endfunction

  // Hex digit value; bit 4 flags a valid digit
  function automatic logic [4:0] digit_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
    if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h61 + 8'd10)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h41 + 8'd10)};
    return 5'd0;
  endfunction

  // Shift in one hex digit; report when the fourth one has arrived
  function automatic logic take_digit(input logic [7:0] c, output logic bad);
    logic [4:0] d;
    d   = digit_value(c);
    bad = ~d[4];
    if (!d[4]) return 1'b0;
    dec_acc = {dec_acc[11:0], d[3:0]};
    if (dec_ndig == 2'd3) begin
      dec_ndig = 2'd0;
      return 1'b1;
    end
    dec_ndig = dec_ndig + 2'd1;
    return 1'b0;
  endfunction

  // Code unit with no high surrogate held before it
  function automatic void single_unit(input logic [15:0] cu);
    if (cu[15:10] == SUR_HIGH_TAG) begin
      dec_held  = cu[9:0];
      dec_phase = PH_HELD;
    end else begin
      add_code_point((cu[15:10] == SUR_LOW_TAG) ? CP_REPL : {5'd0, cu});
      dec_phase = PH_BODY;
    end
  endfunction

  function automatic void body_byte(input logic [7:0] c);
    if (c == CH_QUOTE) close_text(ST_CLOSE);
    else if (c == CH_BSL) dec_phase = PH_ESC;
    else add_word(c, ST_BYTE);
  endfunction

  function automatic void esc_byte(input logic [7:0] c);
    logic [7:0] m;
    logic       known;
    m     = c;
    known = 1'b1;
    case (c)
      CH_QUOTE, CH_BSL, CH_SLASH: m = c;
      CH_N:    m = 8'h0A;
      CH_R:    m = 8'h0D;
      CH_T:    m = 8'h09;
      CH_B:    m = 8'h08;
      CH_F:    m = 8'h0C;
      default: known = 1'b0;
    endcase
    if (c == CH_U) begin
      dec_acc   = '0;
      dec_ndig  = '0;
      dec_phase = PH_HEX;
    end else if (!known) begin
      close_text(ST_ERROR);
    end else begin
      add_word(m, ST_BYTE);
      dec_phase = PH_BODY;
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] c);
    logic bad;
    case (dec_phase)
      PH_BODY: body_byte(c);
      PH_ESC:  esc_byte(c);
      PH_HEX: begin
        if (take_digit(c, bad)) single_unit(dec_acc);
        else if (bad) close_text(ST_ERROR);
      end
      PH_HELD: begin
        if (c == CH_BSL) begin
          dec_phase = PH_HELD_ESC;
        end else begin
          // broken pair: replace the held half, then take the byte plainly
          add_code_point(CP_REPL);
          dec_phase = PH_BODY;
          body_byte(c);
        end
      end
      PH_HELD_ESC: begin
        if (c == CH_U) begin
          dec_acc   = '0;
          dec_ndig  = '0;
          dec_phase = PH_LOW_HEX;
        end else begin
          add_code_point(CP_REPL);
          dec_phase = PH_ESC;
          esc_byte(c);
        end
      end
      PH_LOW_HEX: begin
        if (take_digit(c, bad)) begin
          if (dec_acc[15:10] == SUR_LOW_TAG) begin
            add_code_point(21'({dec_held, dec_acc[9:0]}) + CP_SUPP_BASE);
            dec_phase = PH_BODY;
          end else begin
            // second unit is no low half: replace, then decode it alone
            add_code_point(CP_REPL);
            single_unit(dec_acc);
          end
        end else if (bad) begin
          close_text(ST_ERROR);
        end
      end
      default: ;
    endcase
  endfunction

  // Work out the result words of one accepted text byte and queue them
  function automatic void predict_words(input logic [7:0] c, input logic start,
                                        input logic fin);
    step_words.delete();
    if (start) begin
      clear_decoder();
      if (c == CH_QUOTE) dec_phase = PH_BODY;
      else close_text(ST_ERROR);
    end else if (dec_phase != PH_IDLE) begin
      decode_byte(c);
    end
    // text ends without its closing quote
    if (fin && dec_phase != PH_IDLE) close_text(ST_ERROR);
    if (step_words.size() > 0) step_words[step_words.size() - 1].run_end = 1'b1;
    foreach (step_words[i]) due_words.insert(due_words.size(), step_words[i]);
  endfunction

  function automatic void flag_miss(input string field, input logic [31:0] want,
                                    input logic [31:0] got);
    n_fail++;
    $error("%s: expected %0h, got %0h", field, want, got);
  endfunction

  function automatic void check_word();
    dec_word_t w;
    if (due_words.size() == 0) begin
      n_fail++;
      $error("word with nothing due: out_byte %0h out_status %0h out_run_end %0b",
             out_byte, out_status, out_run_end);
      return;
    end
    w = due_words.pop_front();
    if (out_byte !== w.data) flag_miss("out_byte", w.data, out_byte);
    if (out_status !== w.status) flag_miss("out_status", w.status, out_status);
    if (out_run_end !== w.run_end) flag_miss("out_run_end", w.run_end, out_run_end);
  endfunction

  // Predict on the input side first, then compare on the output side
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_decoder();
      due_words.delete();
      n_fail = 0;
    end else begin
      if (in_valid && in_ready) predict_words(in_byte, in_first, in_final_req);
      if (out_valid && out_ready) check_word();
    end
    n_pending <= due_words.size();
  end

endmodule

// ===== sim/tb_json_string_unescape_utf8_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_json_string_unescape_utf8_top
// Feeds quoted JSON text into the unescaper byte by byte: a few directed texts,
// then mostly well-formed random texts with escapes, surrogate pairs and broken
// pairs mixed in, plus corrupt and noisy ones. Both sides idle at random; the
// checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_json_string_unescape_utf8_top;
  import jsu_pkg::*;

  localparam int N_ITEMS      = 480;
  localparam int IDLE_PCT     = 31;
  localparam int HOLD_CYCLES  = 120;
  localparam int TAIL_CYCLES  = 12;
  localparam int LIMIT_CYCLES = 400000;

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic [7:0] in_byte      = 8'h00;
  logic       in_first     = 1'b0;
  logic       in_final_req = 1'b0;
  logic       out_ready    = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] out_byte;
  logic [1:0] out_status;
  logic       out_run_end;

  int         n_fail;
  int         n_pending;
  int         cycle_cnt    = 0;
  int         n_items      = 0;
  logic       tx_steady    = 1'b0;
  logic       rx_steady    = 1'b0;
  logic       hold_rx      = 1'b0;
  logic [7:0] text_q[$];

  always #6 clk = ~clk;

  json_string_unescape_utf8_top u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .in_first     (in_first),
    .in_final_req (in_final_req),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_status   (out_status),
    .out_run_end  (out_run_end)
  );

  json_string_unescape_utf8_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .in_first     (in_first),
    .in_final_req (in_final_req),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_status   (out_status),
    .out_run_end  (out_run_end),
    .n_fail       (n_fail),
    .n_pending    (n_pending)
  );

  // Stop a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: random back-pressure, one long hold-off on request
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx = 1'b0;
      end else begin
        out_ready <= rx_steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Offer one word and hold it until the block takes it
  task automatic send_word(input logic [7:0] b, input logic start, input logic fin);
    while (!tx_steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_byte      <= b;
    in_first     <= start;
    in_final_req <= fin;
    do @(posedge clk); while (!in_ready);
  endtask

  // Send the built text, start flag on its first byte
  task automatic send_text(input logic fin);
    for (int i = 0; i < text_q.size(); i++)
      send_word(text_q[i], i == 0, fin && (i == text_q.size() - 1));
    n_items += text_q.size();
    text_q.delete();
  endtask

  // Drop valid and wait until every due word has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
  endtask

  // Append one byte to the text being built
  function automatic void text_add(input logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [7:0] esc_letter(input int i);
    case (i)
      0:       return CH_QUOTE;
      1:       return CH_BSL;
      2:       return CH_SLASH;
      3:       return CH_N;
      4:       return CH_R;
      5:       return CH_T;
      6:       return CH_B;
      default: return CH_F;
    endcase
  endfunction

  function automatic logic is_esc(input logic [7:0] c);
    for (int i = 0; i < 8; i++)
      if (c == esc_letter(i)) return 1'b1;
    return c == CH_U;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] bad_hex_char();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (is_hex(b));
    return b;
  endfunction

  function automatic logic [7:0] bad_esc_char();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (is_esc(b));
    return b;
  endfunction

  function automatic void push_unit(input logic [15:0] v);
    text_add(CH_BSL);
    text_add(CH_U);
    for (int i = 3; i >= 0; i--) text_add(hex_char(v[i*4 +: 4]));
  endfunction

  function automatic logic [15:0] high_unit();
    return {SUR_HIGH_TAG, 10'($urandom_range(1023))};
  endfunction

  function automatic logic [15:0] low_unit();
    return {SUR_LOW_TAG, 10'($urandom_range(1023))};
  endfunction

  // Code unit outside the surrogate range, sometimes exactly at a UTF-8 length boundary
  function automatic logic [15:0] bmp_unit();
    logic [15:0] v;
    case ($urandom_range(2))
      0:       v = 16'($urandom_range(16'h7F));
      1:       v = 16'($urandom_range(16'h7FF, 16'h80));
      default: v = 16'($urandom_range(16'hFFFF, 16'h800));
    endcase
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(5))
        0:       v = 16'h0000;
        1:       v = 16'h007F;
        2:       v = 16'h0080;
        3:       v = 16'h07FF;
        4:       v = 16'h0800;
        default: v = 16'hFFFF;
      endcase
    end
    if (v[15:11] == 5'b11011) v[13] = ~v[13];
    return v;
  endfunction

  // Append one random piece of string content
  function automatic void add_token();
    int         r;
    logic [7:0] b;
    r = $urandom_range(99);
    if (r < 35) begin
      b = 8'($urandom_range(255));
      if (b == CH_QUOTE || b == CH_BSL) b ^= 8'h01;
      text_add(b);
    end else if (r < 50) begin
      text_add(CH_BSL);
      text_add(esc_letter($urandom_range(7)));
    end else if (r < 62) begin
      push_unit(bmp_unit());
    end else if (r < 74) begin
      push_unit(high_unit());
      push_unit(low_unit());
    end else if (r < 80) begin
      push_unit(low_unit());
    end else if (r < 92) begin
      // lone high half; whatever follows decides how it resolves
      push_unit(high_unit());
    end else begin
      case ($urandom_range(2))
        0: begin
          // bad hex digit, sometimes inside the second unit of a pair
          if ($urandom_range(1)) push_unit(high_unit());
          text_add(CH_BSL);
          text_add(CH_U);
          repeat ($urandom_range(3)) text_add(hex_char(4'($urandom_range(15))));
          text_add(bad_hex_char());
        end
        1: begin
          text_add(CH_BSL);
          text_add(bad_esc_char());
        end
        default: begin
          // held high half, then an escape other than a unit
          push_unit(high_unit());
          text_add(CH_BSL);
          text_add($urandom_range(1) ? bad_esc_char() : esc_letter($urandom_range(7)));
        end
      endcase
    end
  endfunction

  task automatic random_text();
    int kind;
    int ending;
    kind = $urandom_range(99);
    if (kind < 8) begin
      // noise: random bytes and random flags
      repeat ($urandom_range(6, 1)) begin
        send_word(8'($urandom_range(255)), $urandom_range(99) < 30, $urandom_range(99) < 15);
        n_items++;
      end
    end else begin
      text_add(CH_QUOTE);
      repeat ($urandom_range(6, 1)) add_token();
      ending = $urandom_range(99);
      if (ending < 80) begin
        text_add(CH_QUOTE);
        send_text($urandom_range(99) < 30);
        // a trailing byte after the close is ignored
        if ($urandom_range(99) < 10) begin
          send_word(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
          n_items++;
        end
      end else if (ending < 90) begin
        send_text(1'b1);
      end else begin
        send_text(1'b0);
      end
    end
  endtask

  initial begin
    logic hold_done;
    logic drain_done;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // start on a byte that is no quote
    send_word(8'h78, 1'b1, 1'b0);
    // idle byte with final set: ignored
    send_word(8'hFF, 1'b0, 1'b1);
    // extreme plain bytes, a surrogate pair, close
    text_add(CH_QUOTE);
    text_add(8'h00);
    text_add(8'hFF);
    push_unit(16'hD83D);
    push_unit(16'hDE00);
    text_add(CH_QUOTE);
    send_text(1'b0);
    // unknown escape
    text_add(CH_QUOTE);
    text_add(CH_BSL);
    text_add(8'h71);
    send_text(1'b0);
    // bad hex digit
    text_add(CH_QUOTE);
    text_add(CH_BSL);
    text_add(CH_U);
    text_add(8'h67);
    send_text(1'b0);
    // text ends right at the opening quote
    text_add(CH_QUOTE);
    send_text(1'b1);

    // random texts with a hold-off, a full drain and steady stretches
    while (n_items < N_ITEMS) begin
      if (!hold_done && n_items >= 120) begin
        hold_done = 1'b1;
        hold_rx   = 1'b1;
      end
      if (!drain_done && n_items >= 200) begin
        drain_done = 1'b1;
        wait_drained();
      end
      tx_steady = (n_items >= 240 && n_items < 320) || hold_rx;
      rx_steady = (n_items >= 320 && n_items < 400);
      random_text();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_fail == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/jsu_pkg.sv
sv/json_string_unescape_utf8_top.sv
sv/jsu_checker.sv
sim/json_string_unescape_utf8_checker.sv
sim/tb_json_string_unescape_utf8_top.sv
